// ===== rtl/core/i2cmwr_pkg.sv =====
package i2cmwr_pkg;

  // commands carried in s_axis_tuser
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_EVENT = 2'd2;

  // bus controller events
  localparam logic [2:0] EV_START_DONE = 3'd0;
  localparam logic [2:0] EV_TX_SEL     = 3'd1;
  localparam logic [2:0] EV_BYTE_SENT  = 3'd2;
  localparam logic [2:0] EV_RX_SEL     = 3'd3;
  localparam logic [2:0] EV_BYTE_RECV  = 3'd4;

  // acknowledge control
  localparam logic [1:0] ACK_KEEP    = 2'd0;
  localparam logic [1:0] ACK_DISABLE = 2'd1;
  localparam logic [1:0] ACK_ENABLE  = 2'd2;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUserW = 3;

  // result fields apart from the transmit byte, which comes from the store
  typedef struct packed {
    logic       send_address;
    logic [7:0] address_byte;
    logic       send_data;
    logic       gen_start;
    logic       gen_stop;
    logic [1:0] ack_action;
    logic       events_on;
    logic       rx_valid;
    logic [3:0] rx_index;
    logic [7:0] rx_byte;
    logic       busy_res;
  } res_t;

endpackage

// ===== rtl/core/i2c_master_write_read_sequencer_core.sv =====
// channel      | direction | beat contents
// s_axis       | in        | tuser: cmd; tdata: index, value, counts, event
// m_axis       | out       | tuser: flags; tdata: bytes, requests, status
// cfg          | in        | data: slave_address
//
// one beat per cycle while m_axis is not stalled; a result is registered in the first stage
// (which also reads the transmit store) and then in the output register
// the transmit store is a single synchronous memory, one write and one read per cycle;
// a load is written at the edge it is taken, so the next beat already reads it
// rst_ni clears the counters, pointer and enable flag; the store holds no reset value
// a stalled m_axis holds the pipeline and drops s_axis_tready once both stages are full
module i2c_master_write_read_sequencer_core #(
  parameter int unsigned TX_DEPTH = 16,
  parameter int unsigned RX_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [6:0]                        cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // cmd[1:0]
  input  logic [1:0]                        s_axis_tuser,
  // byte_index[3:0] byte_value[11:4] write_count[16:12] read_count[21:17]
  // event_code[24:22], zero fill above
  input  logic [i2cmwr_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // send_address[0] send_data[1] rx_valid[2]
  output logic [i2cmwr_pkg::OutUserW-1:0]   m_axis_tuser,
  // address_byte[7:0] data_out[15:8] gen_start[16] gen_stop[17] ack_action[19:18]
  // events_on[20] rx_index[24:21] rx_byte[32:25] busy_res[33], zero fill above
  output logic [i2cmwr_pkg::OutDataW-1:0]   m_axis_tdata
);

  localparam int unsigned AW     = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [8:0]  TxLim  = 9'(TX_DEPTH);
  localparam logic [8:0]  RxLim  = 9'(RX_DEPTH);
  localparam logic [8:0]  PtrMax = 9'd256;

  logic [7:0] tx_mem [TX_DEPTH];

  logic [6:0] slave_addr_q;
  logic [8:0] ptr_q, ptr_d;
  logic [4:0] wr_left_q, wr_left_d;
  logic [4:0] rd_left_q, rd_left_d;
  logic       ev_en_q, ev_en_d;

  logic               p1_valid_q;
  i2cmwr_pkg::res_t   p1_res_q;
  i2cmwr_pkg::res_t   res_d;
  logic               p1_dsel_q;
  logic               dsel_d;
  logic [7:0]         mem_rd_q;

  logic                            out_valid_q;
  logic [i2cmwr_pkg::OutDataW-1:0] out_data_q;
  logic [i2cmwr_pkg::OutUserW-1:0] out_user_q;

  logic       in_acc;
  logic       p1_adv;
  logic [1:0] cmd;
  logic [3:0] bidx;
  logic [7:0] bval;
  logic [4:0] wcnt;
  logic [4:0] rcnt;
  logic [2:0] ev;
  logic [8:0] bidx_ext;
  logic       ptr_in_range;
  logic       load_we;
  logic [8:0] ptr_inc;
  logic [7:0] data_out;

  assign cmd  = s_axis_tuser;
  assign bidx = s_axis_tdata[3:0];
  assign bval = s_axis_tdata[11:4];
  assign wcnt = s_axis_tdata[16:12];
  assign rcnt = s_axis_tdata[21:17];
  assign ev   = s_axis_tdata[24:22];

  assign bidx_ext     = {5'd0, bidx};
  assign ptr_in_range = (ptr_q < TxLim);
  assign ptr_inc      = (ptr_q < PtrMax) ? ptr_q + 9'd1 : ptr_q;

  assign p1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !p1_valid_q || p1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_we       = in_acc && (cmd == i2cmwr_pkg::CMD_LOAD) && (bidx_ext < TxLim);
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= '0;
    end else if (cfg_valid_i) begin
      slave_addr_q <= cfg_data_i;
    end
  end

  // transmit store: write at load, read at the current pointer
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      tx_mem[bidx_ext[AW-1:0]] <= bval;
    end
    if (in_acc && ptr_in_range) begin
      mem_rd_q <= tx_mem[ptr_q[AW-1:0]];
    end
  end

  always_comb begin
    ptr_d     = ptr_q;
    wr_left_d = wr_left_q;
    rd_left_d = rd_left_q;
    ev_en_d   = ev_en_q;
    res_d     = '0;
    dsel_d    = 1'b0;
    unique case (cmd)
      i2cmwr_pkg::CMD_START: begin
        wr_left_d       = ({4'd0, wcnt} > TxLim) ? TxLim[4:0] : wcnt;
        rd_left_d       = ({4'd0, rcnt} > RxLim) ? RxLim[4:0] : rcnt;
        ev_en_d         = 1'b1;
        res_d.gen_start = 1'b1;
      end
      i2cmwr_pkg::CMD_EVENT: begin
        if (ev_en_q) begin
          unique case (ev)
            i2cmwr_pkg::EV_START_DONE: begin
              res_d.send_address = 1'b1;
              res_d.address_byte = {slave_addr_q, (wr_left_q == 5'd0)};
              ptr_d              = '0;
            end
            i2cmwr_pkg::EV_TX_SEL: begin
              res_d.send_data = 1'b1;
              dsel_d          = ptr_in_range;
              ptr_d           = ptr_inc;
            end
            i2cmwr_pkg::EV_BYTE_SENT: begin
              if (ptr_q >= {4'd0, wr_left_q}) begin
                wr_left_d = '0;
                if (rd_left_q != 5'd0) begin
                  res_d.gen_start = 1'b1;
                end else begin
                  res_d.gen_stop = 1'b1;
                  ev_en_d        = 1'b0;
                end
              end else begin
                res_d.send_data = 1'b1;
                dsel_d          = ptr_in_range;
                ptr_d           = ptr_inc;
              end
            end
            i2cmwr_pkg::EV_RX_SEL: begin
              if (rd_left_q == 5'd1) begin
                res_d.ack_action = i2cmwr_pkg::ACK_DISABLE;
                res_d.gen_stop   = 1'b1;
              end
            end
            i2cmwr_pkg::EV_BYTE_RECV: begin
              if (rd_left_q != 5'd0) begin
                res_d.rx_valid = 1'b1;
                res_d.rx_index = ptr_q[3:0];
                res_d.rx_byte  = bval;
                ptr_d          = ptr_inc;
                // nack and stop ahead of the final byte
                if (rd_left_q >= 5'd2 && ptr_inc == {4'd0, rd_left_q} - 9'd1) begin
                  res_d.ack_action = i2cmwr_pkg::ACK_DISABLE;
                  res_d.gen_stop   = 1'b1;
                end
                if (ptr_inc >= {4'd0, rd_left_q}) begin
                  ev_en_d          = 1'b0;
                  res_d.ack_action = i2cmwr_pkg::ACK_ENABLE;
                  rd_left_d        = '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    res_d.events_on = ev_en_d;
    res_d.busy_res  = (wr_left_d != 5'd0) || (rd_left_d != 5'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      wr_left_q <= '0;
      rd_left_q <= '0;
      ev_en_q   <= 1'b0;
    end else if (in_acc) begin
      ptr_q     <= ptr_d;
      wr_left_q <= wr_left_d;
      rd_left_q <= rd_left_d;
      ev_en_q   <= ev_en_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        p1_valid_q <= s_axis_tvalid;
      end
      if (p1_adv) begin
        out_valid_q <= p1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p1_res_q  <= res_d;
      p1_dsel_q <= dsel_d;
    end
  end

  assign data_out = p1_dsel_q ? mem_rd_q : 8'd0;

  always_ff @(posedge clk_i) begin
    if (p1_adv && p1_valid_q) begin
      out_user_q <= {p1_res_q.rx_valid, p1_res_q.send_data, p1_res_q.send_address};
      out_data_q <= {6'd0, p1_res_q.busy_res, p1_res_q.rx_byte, p1_res_q.rx_index,
                     p1_res_q.events_on, p1_res_q.ack_action, p1_res_q.gen_stop,
                     p1_res_q.gen_start, data_out, p1_res_q.address_byte};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== rtl/core/i2cmwr_checker.sv =====
module i2cmwr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [i2cmwr_pkg::OutUserW-1:0] m_axis_tuser,
  input logic [i2cmwr_pkg::OutDataW-1:0] m_axis_tdata
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // input only backs up when the output register is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with output empty");

  // a start request always leaves event handling on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[20])
    else $error("start requested with events off");

  // re-enabling ack ends the transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[19:18] == i2cmwr_pkg::ACK_ENABLE)
      |-> !m_axis_tdata[20] && m_axis_tuser[2])
    else $error("ack enabled outside final receive");

  // the address byte and data byte never go out together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("address and data sent in one beat");

endmodule

bind i2c_master_write_read_sequencer_core i2cmwr_checker u_i2cmwr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/i2cmwr_txn_checker.sv =====
module i2cmwr_txn_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [6:0]                      cfg_data_i,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  // cmd[1:0]
  input  logic [1:0]                      s_tuser_i,
  // byte_index[3:0] byte_value[11:4] write_count[16:12] read_count[21:17] event_code[24:22]
  input  logic [i2cmwr_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  // send_address[0] send_data[1] rx_valid[2]
  input  logic [i2cmwr_pkg::OutUserW-1:0] m_tuser_i,
  // address_byte[7:0] data_out[15:8] gen_start[16] gen_stop[17] ack_action[19:18]
  // events_on[20] rx_index[24:21] rx_byte[32:25] busy_res[33]
  input  logic [i2cmwr_pkg::OutDataW-1:0] m_tdata_i,
  output int unsigned                     mismatch_count_o,
  output int unsigned                     pending_o
);

  localparam int unsigned TxDepth = 16;
  localparam int unsigned RxDepth = 16;
  localparam int unsigned PtrCap  = 256;
  localparam int unsigned ShowMax = 10;

  typedef struct packed {
    logic       send_address;
    logic [7:0] address_byte;
    logic       send_data;
    logic [7:0] data_out;
    logic       gen_start;
    logic       gen_stop;
    logic [1:0] ack_action;
    logic       events_on;
    logic       rx_valid;
    logic [3:0] rx_index;
    logic [7:0] rx_byte;
    logic       busy_res;
  } bus_resp_t;

  logic [7:0] tx_bytes [TxDepth];
  logic [8:0] byte_ptr     = '0;
  logic [4:0] writes_due   = '0;
  logic [4:0] reads_due    = '0;
  logic       events_armed = 1'b0;
  logic [6:0] target_addr  = '0;

  bus_resp_t   awaited_resps [$];
  bus_resp_t   want;
  bus_resp_t   got;
  int unsigned fault_count = 0;

  // bytes beyond the store go out as zero
  function automatic logic [7:0] tx_fetch(input logic [8:0] ptr);
    return (ptr < TxDepth) ? tx_bytes[ptr[3:0]] : 8'h00;
  endfunction

  function automatic void bump_ptr();
    if (byte_ptr < PtrCap) byte_ptr = byte_ptr + 9'd1;
  endfunction

  function automatic bus_resp_t sequencer_response(
    input logic [1:0]                     cmd,
    input logic [i2cmwr_pkg::InDataW-1:0] word
  );
    bus_resp_t  r;
    logic [3:0] idx;
    logic [7:0] val;
    logic [4:0] wcnt;
    logic [4:0] rcnt;
    logic [2:0] ev;
    r    = '0;
    idx  = word[3:0];
    val  = word[11:4];
    wcnt = word[16:12];
    rcnt = word[21:17];
    ev   = word[24:22];
    case (cmd)
      i2cmwr_pkg::CMD_LOAD: begin
        tx_bytes[idx] = val;
      end
      i2cmwr_pkg::CMD_START: begin
        writes_due   = (wcnt > TxDepth) ? 5'(TxDepth) : wcnt;
        reads_due    = (rcnt > RxDepth) ? 5'(RxDepth) : rcnt;
        events_armed = 1'b1;
        r.gen_start  = 1'b1;
      end
      i2cmwr_pkg::CMD_EVENT: begin
        if (events_armed) begin
          case (ev)
            i2cmwr_pkg::EV_START_DONE: begin
              r.send_address = 1'b1;
              r.address_byte = {target_addr, writes_due == 5'd0};
              byte_ptr       = '0;
            end
            i2cmwr_pkg::EV_TX_SEL: begin
              r.send_data = 1'b1;
              r.data_out  = tx_fetch(byte_ptr);
              bump_ptr();
            end
            i2cmwr_pkg::EV_BYTE_SENT: begin
              if (byte_ptr >= 9'(writes_due)) begin
                writes_due = '0;
                if (reads_due != 5'd0) begin
                  r.gen_start = 1'b1;
                end else begin
                  r.gen_stop   = 1'b1;
                  events_armed = 1'b0;
                end
              end else begin
                r.send_data = 1'b1;
                r.data_out  = tx_fetch(byte_ptr);
                bump_ptr();
              end
            end
            i2cmwr_pkg::EV_RX_SEL: begin
              if (reads_due == 5'd1) begin
                r.ack_action = i2cmwr_pkg::ACK_DISABLE;
                r.gen_stop   = 1'b1;
              end
            end
            i2cmwr_pkg::EV_BYTE_RECV: begin
              if (reads_due != 5'd0) begin
                r.rx_valid = 1'b1;
                r.rx_index = byte_ptr[3:0];
                r.rx_byte  = val;
                bump_ptr();
                // nack and stop go out ahead of the final byte
                if (reads_due >= 5'd2 && byte_ptr == 9'(reads_due) - 9'd1) begin
                  r.ack_action = i2cmwr_pkg::ACK_DISABLE;
                  r.gen_stop   = 1'b1;
                end
                if (byte_ptr >= 9'(reads_due)) begin
                  events_armed = 1'b0;
                  r.ack_action = i2cmwr_pkg::ACK_ENABLE;
                  reads_due    = '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    r.events_on = events_armed;
    r.busy_res  = (writes_due != 5'd0) || (reads_due != 5'd0);
    return r;
  endfunction

  task automatic cmp_field(input string label, input int unsigned exp_v,
                           input int unsigned act_v);
    if (exp_v != act_v) begin
      fault_count++;
      if (fault_count <= ShowMax)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, label, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_ptr     = '0;
      writes_due   = '0;
      reads_due    = '0;
      events_armed = 1'b0;
      target_addr  = '0;
      awaited_resps.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) target_addr = cfg_data_i;
      if (s_tvalid_i && s_tready_i)
        awaited_resps.push_back(sequencer_response(s_tuser_i, s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got.send_address = m_tuser_i[0];
        got.send_data    = m_tuser_i[1];
        got.rx_valid     = m_tuser_i[2];
        got.address_byte = m_tdata_i[7:0];
        got.data_out     = m_tdata_i[15:8];
        got.gen_start    = m_tdata_i[16];
        got.gen_stop     = m_tdata_i[17];
        got.ack_action   = m_tdata_i[19:18];
        got.events_on    = m_tdata_i[20];
        got.rx_index     = m_tdata_i[24:21];
        got.rx_byte      = m_tdata_i[32:25];
        got.busy_res     = m_tdata_i[33];
        if (awaited_resps.size() == 0) begin
          fault_count++;
          if (fault_count <= ShowMax)
            $display("%0t: result beat with nothing outstanding, got %p", $realtime, got);
        end else begin
          want = awaited_resps.pop_front();
          cmp_field("send_address", want.send_address, got.send_address);
          cmp_field("address_byte", want.address_byte, got.address_byte);
          cmp_field("send_data", want.send_data, got.send_data);
          cmp_field("data_out", want.data_out, got.data_out);
          cmp_field("gen_start", want.gen_start, got.gen_start);
          cmp_field("gen_stop", want.gen_stop, got.gen_stop);
          cmp_field("ack_action", want.ack_action, got.ack_action);
          cmp_field("events_on", want.events_on, got.events_on);
          cmp_field("rx_valid", want.rx_valid, got.rx_valid);
          cmp_field("rx_index", want.rx_index, got.rx_index);
          cmp_field("rx_byte", want.rx_byte, got.rx_byte);
          cmp_field("busy_res", want.busy_res, got.busy_res);
        end
      end
      pending_o <= awaited_resps.size();
    end
    mismatch_count_o <= fault_count;
  end

endmodule

// ===== tb/sv/tb_i2c_master_write_read_sequencer_core.sv =====
module tb_i2c_master_write_read_sequencer_core;

  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam logic [2:0]  EV_OTHER   = 3'd5;
  localparam int unsigned PhaseCount = 8;
  localparam int unsigned PhaseItems = 212;
  localparam int unsigned LongHold   = 150;
  localparam int unsigned RunLimit   = 2_000_000;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [6:0]                      cfg_data_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [1:0]                      s_axis_tuser;
  logic [i2cmwr_pkg::InDataW-1:0]  s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [i2cmwr_pkg::OutUserW-1:0] m_axis_tuser;
  logic [i2cmwr_pkg::OutDataW-1:0] m_axis_tdata;

  int unsigned mismatch_total;
  int unsigned results_pending;

  int unsigned tx_idle_mode  = 1;
  int unsigned rx_idle_mode  = 1;
  int unsigned hold_requests = 0;
  int unsigned phase_beats   = 0;

  i2c_master_write_read_sequencer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  i2cmwr_txn_checker txn_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tuser_i        (s_axis_tuser),
    .s_tdata_i        (s_axis_tdata),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tuser_i        (m_axis_tuser),
    .m_tdata_i        (m_axis_tdata),
    .mismatch_count_o (mismatch_total),
    .pending_o        (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(RunLimit);
    $display("i2c_master_write_read_sequencer_core regression: fail");
    $finish;
  end

  // 0: never idle, 1: idle gap drawn uniformly, 2: mostly back to back
  function automatic int unsigned idle_draw(input int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 16);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  // mostly short transfers, now and then long ones or counts that saturate
  function automatic logic [4:0] pick_count();
    int unsigned s;
    s = $urandom_range(0, 9);
    if (s < 6) return 5'($urandom_range(0, 4));
    if (s < 9) return 5'($urandom_range(0, 16));
    return 5'($urandom_range(17, 31));
  endfunction

  // result side: random stalls per beat, plus the long hold on request
  initial begin
    int unsigned rx_wait;
    int unsigned holds_seen;
    rx_wait       = 0;
    holds_seen    = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) rx_wait = idle_draw(rx_idle_mode);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        rx_wait    = LongHold;
      end
      if (rx_wait > 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic [1:0] cmd, input logic [3:0] idx,
                           input logic [7:0] val, input logic [4:0] wcnt,
                           input logic [4:0] rcnt, input logic [2:0] ev,
                           input bit counted);
    int unsigned gap;
    gap = idle_draw(tx_idle_mode);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, ev, rcnt, wcnt, val, idx};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    if (counted) phase_beats++;
  endtask

  // fields that a command does not use carry random content
  task automatic load_byte(input logic [3:0] idx, input logic [7:0] val);
    send_beat(i2cmwr_pkg::CMD_LOAD, idx, val, 5'($urandom_range(0, 31)),
              5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  task automatic begin_txn(input logic [4:0] wcnt, input logic [4:0] rcnt);
    send_beat(i2cmwr_pkg::CMD_START, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
              wcnt, rcnt, 3'($urandom_range(0, 7)), 1'b1);
  endtask

  task automatic bus_event(input logic [2:0] ev, input logic [7:0] val);
    send_beat(i2cmwr_pkg::CMD_EVENT, 4'($urandom_range(0, 15)), val,
              5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), ev, 1'b1);
  endtask

  // a whole write-then-read transfer as the bus controller would report it;
  // a cut of zero or more abandons it after that many events
  task automatic run_txn(input logic [4:0] wcnt, input logic [4:0] rcnt, input int cut);
    logic [2:0]  evs [$];
    int unsigned wn;
    int unsigned rn;
    wn = (wcnt > 16) ? 16 : wcnt;
    rn = (rcnt > 16) ? 16 : rcnt;
    if (wn > 0) begin
      evs.push_back(i2cmwr_pkg::EV_START_DONE);
      evs.push_back(i2cmwr_pkg::EV_TX_SEL);
      repeat (wn) evs.push_back(i2cmwr_pkg::EV_BYTE_SENT);
    end
    if (rn > 0) begin
      evs.push_back(i2cmwr_pkg::EV_START_DONE);
      evs.push_back(i2cmwr_pkg::EV_RX_SEL);
      repeat (rn) evs.push_back(i2cmwr_pkg::EV_BYTE_RECV);
    end
    if (wn == 0 && rn == 0) begin
      evs.push_back(i2cmwr_pkg::EV_START_DONE);
      evs.push_back(i2cmwr_pkg::EV_BYTE_SENT);
    end
    begin_txn(wcnt, rcnt);
    for (int k = 0; k < evs.size() && (cut < 0 || k < cut); k++)
      bus_event(evs[k], 8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  initial begin
    int unsigned sel;
    logic [7:0]  fill;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = '0;
    s_axis_tdata  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain();
      cfg_valid_i <= 1'b1;
      case (phase)
        0:       cfg_data_i <= 7'h7F;
        1:       cfg_data_i <= 7'h00;
        default: cfg_data_i <= 7'($urandom_range(0, 127));
      endcase
      do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
      cfg_valid_i <= 1'b0;

      case (phase)
        0: begin
          tx_idle_mode <= 1;
          rx_idle_mode <= 1;
        end
        1: begin
          tx_idle_mode <= 0;
          rx_idle_mode <= 0;
        end
        2: begin
          // sender keeps pushing while the result side is held off
          tx_idle_mode  <= 0;
          rx_idle_mode  <= 2;
          hold_requests <= hold_requests + 1;
        end
        default: begin
          tx_idle_mode <= $urandom_range(0, 2);
          rx_idle_mode <= $urandom_range(0, 2);
        end
      endcase
      phase_beats = 0;

      if (phase == 0) begin
        // fill every slot so no transfer reads an unwritten byte
        for (int i = 0; i < 16; i++) begin
          case (i)
            0:       fill = 8'h00;
            1:       fill = 8'hFF;
            2:       fill = 8'h55;
            3:       fill = 8'hAA;
            default: fill = 8'($urandom_range(0, 255));
          endcase
          load_byte(4'(i), fill);
        end
        bus_event(i2cmwr_pkg::EV_TX_SEL, 8'h00);        // ignored, events off
        begin_txn(5'd31, 5'd31);                        // both counts saturate
        begin_txn(5'd2, 5'd1);
        bus_event(i2cmwr_pkg::EV_START_DONE, 8'h00);
        bus_event(i2cmwr_pkg::EV_TX_SEL, 8'h00);
        bus_event(i2cmwr_pkg::EV_BYTE_SENT, 8'h00);
        bus_event(i2cmwr_pkg::EV_BYTE_SENT, 8'h00);     // repeated start for the read
        bus_event(i2cmwr_pkg::EV_START_DONE, 8'h00);
        bus_event(i2cmwr_pkg::EV_RX_SEL, 8'h00);        // single byte read, nack at once
        bus_event(i2cmwr_pkg::EV_BYTE_RECV, 8'hFF);
        begin_txn(5'd0, 5'd0);
        bus_event(i2cmwr_pkg::EV_BYTE_RECV, 8'h00);     // stray receive
        bus_event(EV_OTHER, 8'h5A);
        send_beat(CMD_UNUSED, 4'hF, 8'hFF, 5'd31, 5'd31, 3'd7, 1'b1);
        bus_event(i2cmwr_pkg::EV_START_DONE, 8'h00);
        bus_event(i2cmwr_pkg::EV_BYTE_SENT, 8'h00);     // nothing to do, stop
      end

      while (phase_beats < PhaseItems) begin
        sel = $urandom_range(0, 19);
        if (sel < 14) begin
          run_txn(pick_count(), pick_count(), -1);
        end else if (sel < 16) begin
          run_txn(pick_count(), pick_count(), $urandom_range(0, 6));
        end else if (sel < 18) begin
          repeat ($urandom_range(1, 3))
            load_byte(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(1, 4))
            send_beat(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                      5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)), 1'b0);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_total == 0 && results_pending == 0) begin
      $display("i2c_master_write_read_sequencer_core regression: pass");
    end else begin
      $display("i2c_master_write_read_sequencer_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/i2cmwr_pkg.sv
rtl/core/i2c_master_write_read_sequencer_core.sv
rtl/core/i2cmwr_checker.sv
tb/sv/i2cmwr_txn_checker.sv
tb/sv/tb_i2c_master_write_read_sequencer_core.sv
